/* rtl/sit_pkg.sv */
`timescale 1ns / 1ps

package sit_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
	localparam int CROSS_WIDTH = PROD_WIDTH + 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [CROSS_WIDTH-1:0] cross_t;

	// Sign of one orientation cross product.
	typedef struct packed {
		logic neg;
		logic zero;
	} orient_t;

	// Point p lies inside the inclusive bounding box of the segment a-b.
	function automatic logic in_box(input coord_t px, input coord_t py,
			input coord_t ax, input coord_t ay, input coord_t bx, input coord_t by);
		coord_t xlo;
		coord_t xhi;
		coord_t ylo;
		coord_t yhi;
		xlo = (ax < bx) ? ax : bx;
		xhi = (ax < bx) ? bx : ax;
		ylo = (ay < by) ? ay : by;
		yhi = (ay < by) ? by : ay;
		return (px >= xlo) && (px <= xhi) && (py >= ylo) && (py <= yhi);
	endfunction

	function automatic diff_t sub_ext(input coord_t a, input coord_t b);
		return $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
	endfunction

	function automatic prod_t mul_ext(input diff_t a, input diff_t b);
		return $signed({{DIFF_WIDTH{a[DIFF_WIDTH-1]}}, a})
			* $signed({{DIFF_WIDTH{b[DIFF_WIDTH-1]}}, b});
	endfunction

	function automatic orient_t cross_sign(input prod_t l, input prod_t r);
		cross_t c;
		orient_t o;
		c = $signed({l[PROD_WIDTH-1], l}) - $signed({r[PROD_WIDTH-1], r});
		o.neg  = c[CROSS_WIDTH-1];
		o.zero = (c == '0);
		return o;
	endfunction

endpackage

/* rtl/segment_intersection_test_unit.sv */
`timescale 1ns / 1ps
// Channel | Handshake                    | Payload
// input   | in_valid / in_ready          | seg1_start_x .. seg2_end_y, signed coordinates
// output  | out_valid / out_ready        | segments_meet
//
// One segment pair enters per cycle while the output is not stalled; its answer leaves after the stages below.
// Stages: coordinate differences and box tests, the eight products, the four
// cross-product signs, the final decision in the output register.
// The asynchronous reset clears only the stage valid bits.
// A stalled output freezes every stage at once, so nothing is dropped or repeated.

module segment_intersection_test_unit import sit_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  coord_t seg1_start_x,
	input  coord_t seg1_start_y,
	input  coord_t seg1_end_x,
	input  coord_t seg1_end_y,
	input  coord_t seg2_start_x,
	input  coord_t seg2_start_y,
	input  coord_t seg2_end_x,
	input  coord_t seg2_end_y,
	output logic   out_valid,
	input  logic   out_ready,
	output logic   segments_meet
);

	logic advance;

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	// Differences: dc = D - C, ac = A - C, bc = B - C, ba = B - A, ca = C - A, da = D - A.
	diff_t dcx_s1, dcy_s1, acx_s1, acy_s1, bcx_s1, bcy_s1;
	diff_t bax_s1, bay_s1, cax_s1, cay_s1, dax_s1, day_s1;
	logic [3:0] box_s1, box_s2, box_s3;

	prod_t p1l_s2, p1r_s2, p2l_s2, p2r_s2, p3l_s2, p3r_s2, p4l_s2, p4r_s2;

	orient_t o1_s3, o2_s3, o3_s3, o4_s3;

	logic meet;
	logic straddle12, straddle34;
	logic meet_s4;

	assign advance  = !valid_s4 || out_ready;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dcx_s1 <= sub_ext(seg2_end_x, seg2_start_x);
			dcy_s1 <= sub_ext(seg2_end_y, seg2_start_y);
			acx_s1 <= sub_ext(seg1_start_x, seg2_start_x);
			acy_s1 <= sub_ext(seg1_start_y, seg2_start_y);
			bcx_s1 <= sub_ext(seg1_end_x, seg2_start_x);
			bcy_s1 <= sub_ext(seg1_end_y, seg2_start_y);
			bax_s1 <= sub_ext(seg1_end_x, seg1_start_x);
			bay_s1 <= sub_ext(seg1_end_y, seg1_start_y);
			cax_s1 <= sub_ext(seg2_start_x, seg1_start_x);
			cay_s1 <= sub_ext(seg2_start_y, seg1_start_y);
			dax_s1 <= sub_ext(seg2_end_x, seg1_start_x);
			day_s1 <= sub_ext(seg2_end_y, seg1_start_y);
			box_s1[0] <= in_box(seg1_start_x, seg1_start_y,
				seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y);
			box_s1[1] <= in_box(seg1_end_x, seg1_end_y,
				seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y);
			box_s1[2] <= in_box(seg2_start_x, seg2_start_y,
				seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y);
			box_s1[3] <= in_box(seg2_end_x, seg2_end_y,
				seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y);

			p1l_s2 <= mul_ext(dcx_s1, acy_s1);
			p1r_s2 <= mul_ext(dcy_s1, acx_s1);
			p2l_s2 <= mul_ext(dcx_s1, bcy_s1);
			p2r_s2 <= mul_ext(dcy_s1, bcx_s1);
			p3l_s2 <= mul_ext(bax_s1, cay_s1);
			p3r_s2 <= mul_ext(bay_s1, cax_s1);
			p4l_s2 <= mul_ext(bax_s1, day_s1);
			p4r_s2 <= mul_ext(bay_s1, dax_s1);
			box_s2 <= box_s1;

			o1_s3  <= cross_sign(p1l_s2, p1r_s2);
			o2_s3  <= cross_sign(p2l_s2, p2r_s2);
			o3_s3  <= cross_sign(p3l_s2, p3r_s2);
			o4_s3  <= cross_sign(p4l_s2, p4r_s2);
			box_s3 <= box_s2;

			meet_s4 <= meet;
		end
	end

	// Strict straddle: the two signs are nonzero and opposite.
	assign straddle12 = (o1_s3.neg && !o2_s3.neg && !o2_s3.zero)
		|| (o2_s3.neg && !o1_s3.neg && !o1_s3.zero);
	assign straddle34 = (o3_s3.neg && !o4_s3.neg && !o4_s3.zero)
		|| (o4_s3.neg && !o3_s3.neg && !o3_s3.zero);

	always_comb begin
		meet = (straddle12 && straddle34)
			|| (o1_s3.zero && box_s3[0])
			|| (o2_s3.zero && box_s3[1])
			|| (o3_s3.zero && box_s3[2])
			|| (o4_s3.zero && box_s3[3]);
	end

	assign out_valid     = valid_s4;
	assign segments_meet = meet_s4;

endmodule

/* rtl/sit_checker.sv */
`timescale 1ns / 1ps

module sit_checker import sit_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input coord_t seg1_start_x,
	input coord_t seg1_start_y,
	input coord_t seg1_end_x,
	input coord_t seg1_end_y,
	input coord_t seg2_start_x,
	input coord_t seg2_start_y,
	input coord_t seg2_end_x,
	input coord_t seg2_end_y,
	input logic   out_valid,
	input logic   out_ready,
	input logic   segments_meet
);

	logic all_coords_zero;

	assign all_coords_zero = (seg1_start_x == '0) && (seg1_start_y == '0)
		&& (seg1_end_x == '0) && (seg1_end_y == '0)
		&& (seg2_start_x == '0) && (seg2_start_y == '0)
		&& (seg2_end_x == '0) && (seg2_end_y == '0);

	// A waiting result holds its value until its transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(segments_meet))
		else $error("result changed while stalled");

	// The pipeline only pushes back when a result is waiting and not taken.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input refused with room in the pipeline");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while the pipeline is frozen");

	// Two point segments both at the origin always meet; with no stalls the
	// answer shows once the input transaction has passed the pipeline stages.
	a_point_meet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && all_coords_zero ##1 out_ready ##1 out_ready
		##1 out_ready |=> out_valid && segments_meet)
		else $error("coincident points reported apart");

	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

endmodule

bind segment_intersection_test_unit sit_checker u_sit_checker (.*);

/* tb/sv/segment_intersection_test_unit_tb.sv */
`timescale 1ns / 1ps

module segment_intersection_test_unit_tb;
	import sit_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD_CYCLES = 120;
	localparam int RANDOM_PAIRS = 990;

	typedef struct packed {
		coord_t s1_start_x;
		coord_t s1_start_y;
		coord_t s1_end_x;
		coord_t s1_end_y;
		coord_t s2_start_x;
		coord_t s2_start_y;
		coord_t s2_end_x;
		coord_t s2_end_y;
	} seg_pair_t;

	typedef enum int {
		READY_ALWAYS,
		READY_RANDOM,
		READY_THREE_OF_FOUR,
		READY_SPARSE
	} stall_mode_e;

	typedef enum int {
		PAIR_FULL_RANGE,
		PAIR_TINY,
		PAIR_COLLINEAR,
		PAIR_TOUCHING,
		PAIR_DEGENERATE
	} pair_kind_e;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	seg_pair_t drive_pair;
	logic      out_valid;
	logic      out_ready;
	logic      segments_meet;

	bit        meet_expected[$];
	int        mismatch_count = 0;
	int        idle_cycles = 0;
	int        burst_left = 0;
	bit        hold_armed = 1'b0;
	bit        hold_taken = 1'b0;

	segment_intersection_test_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.seg1_start_x (drive_pair.s1_start_x),
		.seg1_start_y (drive_pair.s1_start_y),
		.seg1_end_x   (drive_pair.s1_end_x),
		.seg1_end_y   (drive_pair.s1_end_y),
		.seg2_start_x (drive_pair.s2_start_x),
		.seg2_start_y (drive_pair.s2_start_y),
		.seg2_end_x   (drive_pair.s2_end_x),
		.seg2_end_y   (drive_pair.s2_end_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.segments_meet(segments_meet)
	);

	always #5 clk = ~clk;

	// Sign of the cross product (b - a) x (c - a). The operands stay far below 2^40.
	function automatic int orient(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy);
		longint area2;
		area2 = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
		return (area2 < 0) ? -1 : ((area2 == 0) ? 0 : 1);
	endfunction

	function automatic bit in_bounds(longint px, longint py, longint ax, longint ay,
			longint bx, longint by);
		longint xlo;
		longint xhi;
		longint ylo;
		longint yhi;
		xlo = (ax < bx) ? ax : bx;
		xhi = (ax < bx) ? bx : ax;
		ylo = (ay < by) ? ay : by;
		yhi = (ay < by) ? by : ay;
		return (px >= xlo) && (px <= xhi) && (py >= ylo) && (py <= yhi);
	endfunction

	function automatic bit pair_meets(seg_pair_t p);
		longint ax;
		longint ay;
		longint bx;
		longint by;
		longint cx;
		longint cy;
		longint dx;
		longint dy;
		int o1;
		int o2;
		int o3;
		int o4;
		ax = longint'(p.s1_start_x);
		ay = longint'(p.s1_start_y);
		bx = longint'(p.s1_end_x);
		by = longint'(p.s1_end_y);
		cx = longint'(p.s2_start_x);
		cy = longint'(p.s2_start_y);
		dx = longint'(p.s2_end_x);
		dy = longint'(p.s2_end_y);
		o1 = orient(cx, cy, dx, dy, ax, ay);
		o2 = orient(cx, cy, dx, dy, bx, by);
		o3 = orient(ax, ay, bx, by, cx, cy);
		o4 = orient(ax, ay, bx, by, dx, dy);
		if (o1 * o2 < 0 && o3 * o4 < 0)
			return 1'b1;
		// An endpoint on the other segment's line counts only inside its box.
		return (o1 == 0 && in_bounds(ax, ay, cx, cy, dx, dy))
			|| (o2 == 0 && in_bounds(bx, by, cx, cy, dx, dy))
			|| (o3 == 0 && in_bounds(cx, cy, ax, ay, bx, by))
			|| (o4 == 0 && in_bounds(dx, dy, ax, ay, bx, by));
	endfunction

	function automatic seg_pair_t make_pair(int ax, int ay, int bx, int by,
			int cx, int cy, int dx, int dy);
		seg_pair_t p;
		p.s1_start_x = coord_t'(ax);
		p.s1_start_y = coord_t'(ay);
		p.s1_end_x   = coord_t'(bx);
		p.s1_end_y   = coord_t'(by);
		p.s2_start_x = coord_t'(cx);
		p.s2_start_y = coord_t'(cy);
		p.s2_end_x   = coord_t'(dx);
		p.s2_end_y   = coord_t'(dy);
		return p;
	endfunction

	function automatic int wide_coord();
		case ($urandom_range(0, 19))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return int'($signed($urandom_range(0, 65535) - 32768));
		endcase
	endfunction

	function automatic int tiny_coord();
		return int'($urandom_range(0, 16)) - 8;
	endfunction

	function automatic int step_range(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Offers one pair and returns at the edge where it is taken. Valid stays high on return.
	task automatic send_pair(input seg_pair_t p, input bit paced);
		int gap;
		if (paced) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
					: $urandom_range(1, 16);
			end
			burst_left--;
		end
		in_valid   <= 1'b1;
		drive_pair <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic test_directed();
		send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 0);
		send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768), 0);
		send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 0);
		send_pair(make_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767), 0);
		send_pair(make_pair(-32768, -32768, 32767, 32767, 32767, -32768, 32767, -32767), 0);
		send_pair(make_pair(32767, -32768, -32768, 32767, 0, 0, -1, -1), 0);
		send_pair(make_pair(0, 0, 4, 4, 0, 4, 4, 0), 0);
		send_pair(make_pair(-5, -5, -1, -1, -5, -1, -1, -5), 0);
		send_pair(make_pair(0, 0, 4, 0, 2, 0, 2, 5), 0);
		send_pair(make_pair(0, 0, 3, 3, 3, 3, 6, 0), 0);
		send_pair(make_pair(0, 0, 4, 0, 2, 0, 6, 0), 0);
		send_pair(make_pair(0, 0, 4, 0, 4, 0, 8, 0), 0);
		send_pair(make_pair(0, 0, 3, 0, 4, 0, 8, 0), 0);
		send_pair(make_pair(0, 0, 10, 10, 2, 2, 3, 3), 0);
		send_pair(make_pair(7, -3, 7, 5, 7, 5, 7, 9), 0);
		send_pair(make_pair(0, 0, 2, 2, 3, 3, 5, 1), 0);
		send_pair(make_pair(1, 1, 1, 1, 0, 0, 2, 2), 0);
		send_pair(make_pair(1, 2, 1, 2, 0, 0, 2, 2), 0);
		send_pair(make_pair(5, 5, 5, 5, 0, 0, 2, 2), 0);
		send_pair(make_pair(1, 1, 1, 1, 2, 2, 2, 2), 0);
		send_pair(make_pair(0, 0, 2, 2, 3, 0, 3, 5), 0);
		send_pair(make_pair(0, 0, 10, 0, 5, 1, 5, 8), 0);
	endtask

	// The receiver holds off for a long stretch while pairs keep coming back to back.
	task automatic test_backpressure();
		int n;
		hold_armed = 1'b1;
		for (n = 0; n < 40; n++)
			send_pair(make_pair(tiny_coord(), tiny_coord(), tiny_coord(), tiny_coord(),
				tiny_coord(), tiny_coord(), tiny_coord(), tiny_coord()), 0);
	endtask

	task automatic test_random();
		int n;
		int pick;
		int bx;
		int by;
		int ddx;
		int ddy;
		int j;
		pair_kind_e kind;
		seg_pair_t p;
		for (n = 0; n < RANDOM_PAIRS; n++) begin
			pick = $urandom_range(0, 99);
			kind = (pick < 30) ? PAIR_FULL_RANGE : (pick < 55) ? PAIR_TINY
				: (pick < 75) ? PAIR_COLLINEAR : (pick < 90) ? PAIR_TOUCHING
				: PAIR_DEGENERATE;
			bx  = step_range(20000);
			by  = step_range(20000);
			ddx = step_range(60);
			ddy = step_range(60);
			case (kind)
				PAIR_FULL_RANGE:
					p = make_pair(wide_coord(), wide_coord(), wide_coord(), wide_coord(),
						wide_coord(), wide_coord(), wide_coord(), wide_coord());
				PAIR_TINY:
					p = make_pair(tiny_coord(), tiny_coord(), tiny_coord(), tiny_coord(),
						tiny_coord(), tiny_coord(), tiny_coord(), tiny_coord());
				PAIR_COLLINEAR: begin
					p = make_pair(0, 0, 0, 0, 0, 0, 0, 0);
					j = step_range(120);
					p.s1_start_x = coord_t'(bx + j * ddx);
					p.s1_start_y = coord_t'(by + j * ddy);
					j = step_range(120);
					p.s1_end_x = coord_t'(bx + j * ddx);
					p.s1_end_y = coord_t'(by + j * ddy);
					j = step_range(120);
					p.s2_start_x = coord_t'(bx + j * ddx);
					p.s2_start_y = coord_t'(by + j * ddy);
					j = step_range(120);
					p.s2_end_x = coord_t'(bx + j * ddx);
					p.s2_end_y = coord_t'(by + j * ddy);
				end
				PAIR_TOUCHING: begin
					j = step_range(120);
					p = make_pair(bx - 100 * ddx, by - 100 * ddy, bx + 100 * ddx, by + 100 * ddy,
						bx + j * ddx, by + j * ddy,
						bx + j * ddx + step_range(500), by + j * ddy + step_range(500));
					if ($urandom_range(0, 1))
						p = {p.s2_end_x, p.s2_end_y, p.s2_start_x, p.s2_start_y,
							p.s1_start_x, p.s1_start_y, p.s1_end_x, p.s1_end_y};
				end
				default: begin
					j = step_range(120);
					if ($urandom_range(0, 1))
						p = make_pair(bx + j * ddx, by + j * ddy, bx + j * ddx, by + j * ddy,
							bx - 100 * ddx, by - 100 * ddy, bx + 100 * ddx, by + 100 * ddy);
					else begin
						p = make_pair(tiny_coord(), tiny_coord(), 0, 0,
							tiny_coord(), tiny_coord(), tiny_coord(), tiny_coord());
						p.s1_end_x = p.s1_start_x;
						p.s1_end_y = p.s1_start_y;
						if ($urandom_range(0, 2) == 0) begin
							p.s2_end_x = p.s2_start_x;
							p.s2_end_y = p.s2_start_y;
						end
					end
				end
			endcase
			send_pair(p, 1);
		end
	endtask

	// Receiver: a changing stall pattern, plus one long hold-off when a test arms it.
	initial begin
		int phase_left;
		int hold_left;
		stall_mode_e mode;
		phase_left = 0;
		hold_left  = 0;
		mode       = READY_ALWAYS;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					mode       = stall_mode_e'($urandom_range(0, 3));
					phase_left = $urandom_range(16, 96);
				end
				phase_left--;
				case (mode)
					READY_ALWAYS:        out_ready <= 1'b1;
					READY_RANDOM:        out_ready <= ($urandom_range(0, 1) == 1);
					READY_THREE_OF_FOUR: out_ready <= (phase_left % 4 != 0);
					default:             out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Results are checked before the pair taken at the same edge is predicted.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (meet_expected.size() == 0) begin
				$error("unexpected result transaction: segments_meet actual %0b", segments_meet);
				mismatch_count++;
			end else if (segments_meet !== meet_expected[0]) begin
				$error("segments_meet mismatch: expected %0b, actual %0b",
					meet_expected[0], segments_meet);
				mismatch_count++;
				void'(meet_expected.pop_front());
			end else begin
				void'(meet_expected.pop_front());
			end
		end
		if (in_valid && in_ready)
			meet_expected.push_back(pair_meets(drive_pair));
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		drive_pair <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;
		while (meet_expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
rtl/sit_pkg.sv
rtl/segment_intersection_test_unit.sv
rtl/sit_checker.sv
tb/sv/segment_intersection_test_unit_tb.sv
